FILE: design/vntc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vntc_pkg: shared types and constants of the neighbor table classifier
// Placement and list select codes, heading thresholds, subtractor width.
// ----------------------------------------------------------------------------
package vntc_pkg;

	// default sizing of the neighbor lists
	localparam int MAX_NEIGHBORS_DEF = 5;
	localparam int ID_WIDTH_DEF      = 16;

	// field widths
	localparam int POS_W  = 32;
	localparam int HDG_W  = 9;
	localparam int ROI_W  = 30;
	localparam int PLC_W  = 3;
	localparam int DIFF_W = POS_W + 1;
	localparam int ALU_W  = POS_W + 2;

	localparam logic [ROI_W-1:0] ROI_RESET = 30'd40000;

	// heading thresholds in degrees
	localparam logic [HDG_W-1:0] HDG_45  = 9'd45;
	localparam logic [HDG_W-1:0] HDG_90  = 9'd90;
	localparam logic [HDG_W-1:0] HDG_135 = 9'd135;
	localparam logic [HDG_W-1:0] HDG_180 = 9'd180;
	localparam logic [HDG_W-1:0] HDG_225 = 9'd225;
	localparam logic [HDG_W-1:0] HDG_315 = 9'd315;
	localparam logic [HDG_W-1:0] HDG_360 = 9'd360;

	// placement codes
	localparam logic [PLC_W-1:0] PLACE_OUTSIDE = 3'd0;
	localparam logic [PLC_W-1:0] PLACE_FRONT   = 3'd1;
	localparam logic [PLC_W-1:0] PLACE_BACK    = 3'd2;
	localparam logic [PLC_W-1:0] PLACE_OPP     = 3'd3;
	localparam logic [PLC_W-1:0] PLACE_IGNORED = 3'd4;

	// list select codes
	localparam int NUM_LISTS = 3;
	typedef logic [1:0] list_sel_t;
	localparam list_sel_t LIST_FRONT = 2'd0;
	localparam list_sel_t LIST_BACK  = 2'd1;
	localparam list_sel_t LIST_OPP   = 2'd2;

	// store request from the sequencer to the list store
	typedef struct packed {
		logic      store;
		list_sel_t sel;
	} list_req_t;

	// occupancy of the three lists
	typedef struct packed {
		logic front_nz;
		logic back_nz;
		logic opp_nz;
	} list_stat_t;

endpackage
`default_nettype wire

FILE: design/vntc_alu.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vntc_alu: shared subtractor
// Signed a - b with a sign flag, used by the region and heading steps of the sequencer.
// ----------------------------------------------------------------------------
module vntc_alu
	import vntc_pkg::*;
(
	input  wire logic signed [ALU_W-1:0] op_a,
	input  wire logic signed [ALU_W-1:0] op_b,
	output logic signed [ALU_W-1:0]      diff,
	output logic                         neg
);

	// one wide subtract, sign from the result
	always_comb begin
		diff = op_a - op_b;
		neg  = diff[ALU_W-1];
	end

endmodule
`default_nettype wire

FILE: design/vntc_lists.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vntc_lists: front, back and opposite neighbor lists
// Removes an id from all lists, appends it to one, trims the oldest entry when full.
// ----------------------------------------------------------------------------
module vntc_lists
	import vntc_pkg::*;
#(
	parameter int MAX_NEIGHBORS = MAX_NEIGHBORS_DEF,
	parameter int ID_WIDTH      = ID_WIDTH_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire list_req_t           req,
	input  wire logic [ID_WIDTH-1:0] id,
	output list_stat_t               stat
);

	localparam int CW = $clog2(MAX_NEIGHBORS + 1);
	localparam logic [CW-1:0] FULL = CW'(MAX_NEIGHBORS);

	logic [ID_WIDTH-1:0] list_q   [NUM_LISTS][MAX_NEIGHBORS];
	logic [CW-1:0]       count_q  [NUM_LISTS];
	logic [ID_WIDTH-1:0] list_nxt [NUM_LISTS][MAX_NEIGHBORS];
	logic [CW-1:0]       count_nxt[NUM_LISTS];
	logic [ID_WIDTH-1:0] kept     [NUM_LISTS][MAX_NEIGHBORS];
	logic [ID_WIDTH-1:0] kept_sh  [NUM_LISTS][MAX_NEIGHBORS];
	logic [ID_WIDTH-1:0] raw_sh   [NUM_LISTS][MAX_NEIGHBORS];
	logic [CW-1:0]       kept_cnt [NUM_LISTS];
	logic [MAX_NEIGHBORS-1:0] hit [NUM_LISTS];

	// drop the id from every list, then append to the selected one
	always_comb begin
		logic seen;
		for (int l = 0; l < NUM_LISTS; l++) begin
			// neighbor of each entry one place up
			for (int i = 0; i < MAX_NEIGHBORS - 1; i++) begin
				raw_sh[l][i] = list_q[l][i+1];
			end
			raw_sh[l][MAX_NEIGHBORS-1] = list_q[l][MAX_NEIGHBORS-1];

			// an id is held at most once, so a drop closes one gap
			seen = 1'b0;
			for (int i = 0; i < MAX_NEIGHBORS; i++) begin
				hit[l][i] = (CW'(i) < count_q[l]) && (list_q[l][i] == id);
				seen      = seen | hit[l][i];
				kept[l][i] = seen ? raw_sh[l][i] : list_q[l][i];
			end
			kept_cnt[l] = count_q[l] - CW'(seen);

			for (int i = 0; i < MAX_NEIGHBORS - 1; i++) begin
				kept_sh[l][i] = kept[l][i+1];
			end
			kept_sh[l][MAX_NEIGHBORS-1] = id;

			list_nxt[l]  = list_q[l];
			count_nxt[l] = count_q[l];
			if (req.store) begin
				list_nxt[l]  = kept[l];
				count_nxt[l] = kept_cnt[l];
				if (req.sel == list_sel_t'(l)) begin
					if (kept_cnt[l] >= FULL) begin
						// full list: oldest entry leaves
						list_nxt[l]  = kept_sh[l];
						count_nxt[l] = FULL;
					end else begin
						for (int i = 0; i < MAX_NEIGHBORS; i++) begin
							if (CW'(i) == kept_cnt[l]) begin
								list_nxt[l][i] = id;
							end
						end
						count_nxt[l] = kept_cnt[l] + 1'b1;
					end
				end
			end
		end
	end

	// list contents, no reset
	always_ff @(posedge clk) begin
		list_q <= list_nxt;
	end

	// fill counts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int l = 0; l < NUM_LISTS; l++) begin
				count_q[l] <= '0;
			end
		end else begin
			count_q <= count_nxt;
		end
	end

	// occupancy
	always_comb begin
		stat.front_nz = (count_q[LIST_FRONT] != '0);
		stat.back_nz  = (count_q[LIST_BACK] != '0);
		stat.opp_nz   = (count_q[LIST_OPP] != '0);
	end

	// a store to the opposite list leaves that list non-empty
	a_store_fills: assert property (@(posedge clk) disable iff (!arst_n)
		req.store && req.sel == LIST_OPP |=> count_q[LIST_OPP] != '0)
		else $error("opposite list empty after store");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q[LIST_FRONT] <= FULL && count_q[LIST_BACK] <= FULL
		&& count_q[LIST_OPP] <= FULL)
		else $error("list count above capacity");

	// counts only move on a store
	a_count_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!req.store |=> count_q[LIST_FRONT] == $past(count_q[LIST_FRONT])
		&& count_q[LIST_BACK] == $past(count_q[LIST_BACK])
		&& count_q[LIST_OPP] == $past(count_q[LIST_OPP]))
		else $error("list count moved without a store");

endmodule
`default_nettype wire

FILE: design/vehicle_neighbor_table_classifier_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vehicle_neighbor_table_classifier_unit: neighbor table classifier
// Region test, heading fold and list placement of one hello per item.
// ----------------------------------------------------------------------------
// Sequence: dx, dy, four region checks, heading gap, fold, list store, output;
//   an ignored heading gap skips the store, a sender outside the region skips the rest.
// Input: in_stall holds off a new item until the last one has left the output step;
//   region and heading steps each take one pass through the shared subtractor.
// Reset: arst_n clears the sequencer, list counts and output valid; region
//   half width returns to 40000.
module vehicle_neighbor_table_classifier_unit
	import vntc_pkg::*;
#(
	parameter int MAX_NEIGHBORS = MAX_NEIGHBORS_DEF,
	parameter int ID_WIDTH      = ID_WIDTH_DEF
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    cfg_wr_en,
	input  wire logic [ROI_W-1:0]        cfg_wr_data,
	input  wire logic                    in_valid,
	output logic                         in_stall,
	input  wire logic [15:0]             sender_id,
	input  wire logic [HDG_W-1:0]        sender_heading,
	input  wire logic signed [POS_W-1:0] sender_x,
	input  wire logic signed [POS_W-1:0] sender_y,
	input  wire logic [HDG_W-1:0]        own_heading,
	input  wire logic signed [POS_W-1:0] own_x,
	input  wire logic signed [POS_W-1:0] own_y,
	output logic                         out_valid,
	input  wire logic                    out_stall,
	output logic [PLC_W-1:0]             placement,
	output logic                         same_direction_connected,
	output logic                         opposite_connected
);

	// sequencer states
	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_DX    = 4'd1;
	localparam logic [3:0] ST_DY    = 4'd2;
	localparam logic [3:0] ST_CX_HI = 4'd3;
	localparam logic [3:0] ST_CX_LO = 4'd4;
	localparam logic [3:0] ST_CY_HI = 4'd5;
	localparam logic [3:0] ST_CY_LO = 4'd6;
	localparam logic [3:0] ST_HD    = 4'd7;
	localparam logic [3:0] ST_HF    = 4'd8;
	localparam logic [3:0] ST_STORE = 4'd9;
	localparam logic [3:0] ST_OUT   = 4'd10;

	logic [3:0]              state_q;
	logic [ROI_W-1:0]        roi_q;
	logic [ID_WIDTH-1:0]     id_q;
	logic [HDG_W-1:0]        sh_q;
	logic [HDG_W-1:0]        oh_q;
	logic signed [POS_W-1:0] sx_q;
	logic signed [POS_W-1:0] sy_q;
	logic signed [POS_W-1:0] ox_q;
	logic signed [POS_W-1:0] oy_q;
	logic signed [DIFF_W-1:0] dx_q;
	logic signed [DIFF_W-1:0] dy_q;
	logic [HDG_W-1:0]        hdiff_q;
	logic [PLC_W-1:0]        placement_q;
	list_sel_t               sel_q;
	logic                    out_valid_q;
	logic [PLC_W-1:0]        out_place_q;
	logic                    out_same_q;
	logic                    out_opp_q;

	logic signed [ALU_W-1:0] alu_a;
	logic signed [ALU_W-1:0] alu_b;
	logic signed [ALU_W-1:0] alu_diff;
	logic                    alu_neg;
	logic [ALU_W-1:0]        roi_ext;
	logic [HDG_W-1:0]        hd_abs;
	logic [HDG_W-1:0]        folded;
	logic                    ahead;
	logic                    in_take;
	logic                    out_free;
	list_req_t               req;
	list_stat_t              stat;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_take   = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign roi_ext   = {{(ALU_W - ROI_W){1'b0}}, roi_q};

	// operand select for the shared subtractor
	always_comb begin
		alu_a = '0;
		alu_b = '0;
		case (state_q)
			ST_DX: begin
				alu_a = {{(ALU_W - POS_W){ox_q[POS_W-1]}}, ox_q};
				alu_b = {{(ALU_W - POS_W){sx_q[POS_W-1]}}, sx_q};
			end
			ST_DY: begin
				alu_a = {{(ALU_W - POS_W){oy_q[POS_W-1]}}, oy_q};
				alu_b = {{(ALU_W - POS_W){sy_q[POS_W-1]}}, sy_q};
			end
			ST_CX_HI: begin
				alu_a = {{(ALU_W - DIFF_W){dx_q[DIFF_W-1]}}, dx_q};
				alu_b = roi_ext;
			end
			ST_CX_LO: begin
				alu_a = ALU_W'(0) - roi_ext;
				alu_b = {{(ALU_W - DIFF_W){dx_q[DIFF_W-1]}}, dx_q};
			end
			ST_CY_HI: begin
				alu_a = {{(ALU_W - DIFF_W){dy_q[DIFF_W-1]}}, dy_q};
				alu_b = roi_ext;
			end
			ST_CY_LO: begin
				alu_a = ALU_W'(0) - roi_ext;
				alu_b = {{(ALU_W - DIFF_W){dy_q[DIFF_W-1]}}, dy_q};
			end
			ST_HD: begin
				alu_a = {{(ALU_W - HDG_W){1'b0}}, sh_q};
				alu_b = {{(ALU_W - HDG_W){1'b0}}, oh_q};
			end
			ST_HF: begin
				alu_a = {{(ALU_W - HDG_W){1'b0}}, HDG_360};
				alu_b = {{(ALU_W - HDG_W){1'b0}}, hdiff_q};
			end
			default: begin
				alu_a = '0;
				alu_b = '0;
			end
		endcase
	end

	vntc_alu u_alu (
		.op_a (alu_a),
		.op_b (alu_b),
		.diff (alu_diff),
		.neg  (alu_neg)
	);

	// heading magnitude, fold above 180, sector test on the sender heading
	always_comb begin
		hd_abs = alu_neg ? HDG_W'(~alu_diff + 1'b1) : alu_diff[HDG_W-1:0];
		folded = (hdiff_q > HDG_180) ? alu_diff[HDG_W-1:0] : hdiff_q;
		if (sh_q < HDG_45 || sh_q >= HDG_315) begin
			ahead = dx_q[DIFF_W-1];
		end else if (sh_q inside {[HDG_45:HDG_135 - 9'd1]}) begin
			ahead = dy_q[DIFF_W-1];
		end else if (sh_q < HDG_225) begin
			ahead = !dx_q[DIFF_W-1] && (dx_q != '0);
		end else begin
			ahead = !dy_q[DIFF_W-1] && (dy_q != '0);
		end
	end

	assign req.store = (state_q == ST_STORE);
	assign req.sel   = sel_q;

	vntc_lists #(
		.MAX_NEIGHBORS (MAX_NEIGHBORS),
		.ID_WIDTH      (ID_WIDTH)
	) u_lists (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.id     (id_q),
		.stat   (stat)
	);

	// region half width register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			roi_q <= ROI_RESET;
		end else if (cfg_wr_en) begin
			roi_q <= cfg_wr_data;
		end
	end

	// item capture with heading wrap
	always_ff @(posedge clk) begin
		if (in_take) begin
			id_q <= ID_WIDTH'(sender_id);
			sh_q <= (sender_heading >= HDG_360) ? sender_heading - HDG_360 : sender_heading;
			oh_q <= (own_heading >= HDG_360) ? own_heading - HDG_360 : own_heading;
			sx_q <= sender_x;
			sy_q <= sender_y;
			ox_q <= own_x;
			oy_q <= own_y;
		end
	end

	// working registers loaded from the subtractor
	always_ff @(posedge clk) begin
		case (state_q)
			ST_DX: dx_q <= alu_diff[DIFF_W-1:0];
			ST_DY: dy_q <= alu_diff[DIFF_W-1:0];
			ST_HD: hdiff_q <= hd_abs;
			default: begin
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			placement_q <= PLACE_OUTSIDE;
			sel_q       <= LIST_FRONT;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_take) begin
						state_q <= ST_DX;
					end
				end
				ST_DX: state_q <= ST_DY;
				ST_DY: state_q <= ST_CX_HI;
				ST_CX_HI, ST_CX_LO, ST_CY_HI: begin
					if (!alu_neg) begin
						placement_q <= PLACE_OUTSIDE;
						state_q     <= ST_OUT;
					end else begin
						state_q <= state_q + 4'd1;
					end
				end
				ST_CY_LO: begin
					if (!alu_neg) begin
						placement_q <= PLACE_OUTSIDE;
						state_q     <= ST_OUT;
					end else begin
						state_q <= ST_HD;
					end
				end
				ST_HD: state_q <= ST_HF;
				ST_HF: begin
					if (folded <= HDG_45) begin
						placement_q <= ahead ? PLACE_FRONT : PLACE_BACK;
						sel_q       <= ahead ? LIST_FRONT : LIST_BACK;
						state_q     <= ST_STORE;
					end else if (folded > HDG_90) begin
						placement_q <= PLACE_OPP;
						sel_q       <= LIST_OPP;
						state_q     <= ST_STORE;
					end else begin
						placement_q <= PLACE_IGNORED;
						state_q     <= ST_OUT;
					end
				end
				ST_STORE: state_q <= ST_OUT;
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_OUT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// flags follow the counts; an outside hello leaves counts alone
	always_ff @(posedge clk) begin
		if (state_q == ST_OUT && out_free) begin
			out_place_q <= placement_q;
			out_same_q  <= stat.front_nz && stat.back_nz;
			out_opp_q   <= stat.opp_nz;
		end
	end

	assign out_valid                = out_valid_q;
	assign placement                = out_place_q;
	assign same_direction_connected = out_same_q;
	assign opposite_connected       = out_opp_q;

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_take |=> state_q == ST_DX)
		else $error("accepted item did not start the sequence");

	a_valid_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == ST_OUT)
		else $error("result raised outside the output step");

	a_front_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_OUT && (placement_q == PLACE_FRONT || placement_q == PLACE_BACK)
		|-> (stat.front_nz || stat.back_nz))
		else $error("same-direction placement with empty lists");

	a_opp_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_OUT && placement_q == PLACE_OPP |-> stat.opp_nz)
		else $error("opposite placement with empty opposite list");

endmodule
`default_nettype wire
